### rtl/maa_pkg.sv
// Shared constants, codes and types of the motion activity accumulator.
// Used by the channel interfaces and by every module of the block except the generic RAM.
package maa_pkg;

   // History ring geometry.
   localparam int HIST_DEPTH = 16;
   localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

   // Field widths.
   localparam int ACTION_W = 3;
   localparam int ACCEL_W  = 14;
   localparam int SLOT_W   = 4;
   localparam int TICKS_W  = 17;
   localparam int COUNT_W  = 5;
   localparam int TOTAL_W  = 32;
   localparam int SCALED_W = 11;
   localparam int INC_W    = 8;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   // Reset values of the configuration registers.
   localparam logic [TICKS_W-1:0] TICKS_RESET = 17'd3600;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd1;

   // Division by ten as a multiply by 6554 / 2^16; exact for magnitudes up to 8192.
   localparam int RECIP_W     = 13;
   localparam logic [RECIP_W-1:0] RECIP_TEN = 13'd6554;
   localparam int RECIP_SHIFT = 16;

   // Action codes of the request channel.
   localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_START = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_READ  = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL_TICKS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL_COUNT = 8'd1;

   typedef logic signed [SCALED_W-1:0] scaled_type;

   typedef struct packed {
      logic                running;
      logic [TOTAL_W-1:0]  activity_total;
      logic [COUNT_W-1:0]  cycles_left;
      logic                interval_closed;
      logic [TOTAL_W-1:0]  history_value;
      logic [SLOT_W-1:0]   next_write_slot;
   } rsp_type;

endpackage

### rtl/maa_if.sv
// Valid/ready channel interfaces of the motion activity accumulator: request,
// response and configuration write. Depends on maa_pkg.
interface maa_req_if import maa_pkg::*; ;
   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic signed [ACCEL_W-1:0]  accel_x;
   logic signed [ACCEL_W-1:0]  accel_y;
   logic signed [ACCEL_W-1:0]  accel_z;
   logic [SLOT_W-1:0]          history_slot;

   modport source (output valid, action, accel_x, accel_y, accel_z, history_slot,
                   input ready);
   modport sink   (input valid, action, accel_x, accel_y, accel_z, history_slot,
                   output ready);
endinterface

interface maa_rsp_if import maa_pkg::*; ;
   logic                valid;
   logic                ready;
   logic                running;
   logic [TOTAL_W-1:0]  activity_total;
   logic [COUNT_W-1:0]  cycles_left;
   logic                interval_closed;
   logic [TOTAL_W-1:0]  history_value;
   logic [SLOT_W-1:0]   next_write_slot;

   modport source (output valid, running, activity_total, cycles_left, interval_closed,
                   history_value, next_write_slot, input ready);
   modport sink   (input valid, running, activity_total, cycles_left, interval_closed,
                   history_value, next_write_slot, output ready);
endinterface

interface maa_csr_if import maa_pkg::*; ;
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/motion_activity_accumulator.sv
// Motion activity accumulator, top level. Built from maa_pkg, the channel interfaces
// in maa_if, the shared divide-by-ten unit maa_div10 and the history RAM maa_ram.
//
// The block takes one request transaction at a time and answers each with exactly one
// response transaction. A tick while running scales each of the three axes to mg/10,
// takes the absolute change from that axis's previous scaled value, divides it by ten
// and adds it to a saturating 32-bit activity total; the interval countdown then either
// steps down or closes the interval, which writes the total to the 16-entry history
// ring and clears it. Start, stop, clear history and read history act on the same state.
// A tick while running goes from ST_IDLE, where it is accepted, through ST_SCALE,
// ST_DIFF and ST_ACC for each axis: a single divide-by-ten multiplier is shared across
// the three axes, with one pass for the scaling, one for the change and a saturating
// add per axis. ST_DONE then updates the counters and writes the response register. A
// read passes ST_READ for the registered RAM read before ST_DONE; any other request
// goes to ST_DONE. The response sits in an output register, so the next one can be
// accepted while a response still waits to be taken; the block only stalls when a
// second result is ready while the first has not left. Configuration writes are always
// taken and must only be issued while the block is idle. Clearing the history takes
// no extra time: per-entry valid bits make unwritten entries read as 0.
module motion_activity_accumulator import maa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   maa_req_if.sink    req_if,
   maa_rsp_if.source  rsp_if,
   maa_csr_if.sink    csr_if
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCALE = 3'd1;
   localparam logic [2:0] ST_DIFF  = 3'd2;
   localparam logic [2:0] ST_ACC   = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam logic [1:0] LAST_AXIS = 2'd2;

   logic [2:0]                 state_ff, state_in;
   logic [1:0]                 axis_ff, axis_in;

   // Latched request.
   logic [ACTION_W-1:0]        act_ff;
   logic signed [ACCEL_W-1:0]  accel_ff [3];
   logic [SLOT_W-1:0]          slot_ff;

   // Working registers of the shared unit.
   scaled_type                 now_ff, now_in;
   logic [INC_W-1:0]           inc_ff, inc_in;

   // Architectural state.
   scaled_type                 scaled_ff [3];
   scaled_type                 scaled_in [3];
   logic [TOTAL_W-1:0]         total_ff, total_in;
   logic [TICKS_W-1:0]         countdown_ff, countdown_in;
   logic [COUNT_W-1:0]         cycles_ff, cycles_in;
   logic                       run_ff, run_in;
   logic [TICKS_W-1:0]         ticks_ff, ticks_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic [HIST_AW-1:0]         wslot_ff, wslot_in;
   logic [HIST_DEPTH-1:0]      hvalid_ff, hvalid_in;

   // Response register.
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;

   logic                       req_take;
   logic                       csr_take;
   logic                       out_free;
   logic signed [ACCEL_W-1:0]  unit_in;
   scaled_type                 unit_out;
   logic signed [SCALED_W:0]   diff;
   logic [SCALED_W-1:0]        q_mag;
   logic [TOTAL_W:0]           sum;
   logic                       ram_we;
   logic                       ram_re;
   logic [TOTAL_W-1:0]         ram_rd_data;
   logic [HIST_AW-1:0]         rd_addr;
   logic                       slot_in_range;
   logic                       closed;
   logic [TOTAL_W-1:0]         hist;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;
   assign csr_take     = csr_if.valid;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   // Shared unit: scales the raw sample in ST_SCALE and divides the change in ST_DIFF.
   assign diff    = {scaled_ff[axis_ff][SCALED_W-1], scaled_ff[axis_ff]}
                  - {now_ff[SCALED_W-1], now_ff};
   assign unit_in = (state_ff == ST_SCALE) ? accel_ff[axis_ff]
                  : {{(ACCEL_W-SCALED_W-1){diff[SCALED_W]}}, diff};

   maa_div10 u_div10 (
      .dividend (unit_in),
      .quotient (unit_out)
   );

   assign q_mag = unit_out[SCALED_W-1] ? (~unit_out + 1'b1) : unit_out;
   assign sum   = {1'b0, total_ff} + (TOTAL_W+1)'(inc_ff);

   assign rd_addr       = HIST_AW'(slot_ff);
   assign slot_in_range = (9'(slot_ff) < 9'(HIST_DEPTH));
   assign ram_re        = (state_ff == ST_READ);

   maa_ram #(
      .WIDTH (TOTAL_W),
      .DEPTH (HIST_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wslot_ff),
      .wr_data (total_ff),
      .rd_en   (ram_re),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      now_in       = now_ff;
      inc_in       = inc_ff;
      scaled_in    = scaled_ff;
      total_in     = total_ff;
      countdown_in = countdown_ff;
      cycles_in    = cycles_ff;
      run_in       = run_ff;
      ticks_in     = ticks_ff;
      count_in     = count_ff;
      wslot_in     = wslot_ff;
      hvalid_in    = hvalid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      closed       = 1'b0;
      hist         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               axis_in = 2'd0;
               if (req_if.action == ACT_TICK && run_ff) begin
                  state_in = ST_SCALE;
               end else if (req_if.action == ACT_READ) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCALE: begin
            now_in   = unit_out;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            inc_in             = q_mag[INC_W-1:0];
            scaled_in[axis_ff] = now_ff;
            state_in           = ST_ACC;
         end
         ST_ACC: begin
            // Saturate at all ones when the add carries out.
            total_in = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            if (axis_ff == LAST_AXIS) begin
               state_in = ST_DONE;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_SCALE;
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               case (act_ff)
                  ACT_TICK: begin
                     if (run_ff) begin
                        if (countdown_ff > 17'd1) begin
                           countdown_in = countdown_ff - 17'd1;
                        end else begin
                           if (cycles_ff > 5'd1) begin
                              countdown_in = ticks_ff;
                              cycles_in    = cycles_ff - 5'd1;
                           end else begin
                              cycles_in = '0;
                              run_in    = 1'b0;
                           end
                           ram_we              = 1'b1;
                           hvalid_in[wslot_ff] = 1'b1;
                           wslot_in = (wslot_ff == HIST_AW'(HIST_DEPTH-1)) ? '0
                                    : wslot_ff + 1'b1;
                           total_in = '0;
                           closed   = 1'b1;
                        end
                     end
                  end
                  ACT_START: begin
                     if (cycles_ff == '0) begin
                        countdown_in = ticks_ff;
                        cycles_in    = count_ff;
                     end
                     run_in = 1'b1;
                  end
                  ACT_STOP: begin
                     run_in = 1'b0;
                  end
                  ACT_CLEAR: begin
                     hvalid_in    = '0;
                     wslot_in     = '0;
                     countdown_in = ticks_ff;
                     cycles_in    = count_ff;
                     total_in     = '0;
                  end
                  ACT_READ: begin
                     if (slot_in_range && hvalid_ff[rd_addr]) begin
                        hist = ram_rd_data;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_in.running         = run_in;
               rsp_in.activity_total  = total_in;
               rsp_in.cycles_left     = cycles_in;
               rsp_in.interval_closed = closed;
               rsp_in.history_value   = hist;
               rsp_in.next_write_slot = SLOT_W'(wslot_in);
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A register write that changes the value reloads the counter it governs.
      if (csr_take) begin
         case (csr_if.index)
            REG_INTERVAL_TICKS: begin
               if (csr_if.data[TICKS_W-1:0] != ticks_ff) begin
                  ticks_in     = csr_if.data[TICKS_W-1:0];
                  countdown_in = csr_if.data[TICKS_W-1:0];
                  total_in     = '0;
               end
            end
            REG_INTERVAL_COUNT: begin
               if (csr_if.data[COUNT_W-1:0] != count_ff) begin
                  count_in  = csr_if.data[COUNT_W-1:0];
                  cycles_in = csr_if.data[COUNT_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         scaled_ff    <= '{default: '0};
         total_ff     <= '0;
         countdown_ff <= TICKS_RESET;
         cycles_ff    <= COUNT_RESET;
         run_ff       <= 1'b0;
         ticks_ff     <= TICKS_RESET;
         count_ff     <= COUNT_RESET;
         wslot_ff     <= '0;
         hvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         scaled_ff    <= scaled_in;
         total_ff     <= total_in;
         countdown_ff <= countdown_in;
         cycles_ff    <= cycles_in;
         run_ff       <= run_in;
         ticks_ff     <= ticks_in;
         count_ff     <= count_in;
         wslot_ff     <= wslot_in;
         hvalid_ff    <= hvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         act_ff      <= req_if.action;
         accel_ff[0] <= req_if.accel_x;
         accel_ff[1] <= req_if.accel_y;
         accel_ff[2] <= req_if.accel_z;
         slot_ff     <= req_if.history_slot;
      end
      now_ff <= now_in;
      inc_ff <= inc_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.running         = rsp_ff.running;
   assign rsp_if.activity_total  = rsp_ff.activity_total;
   assign rsp_if.cycles_left     = rsp_ff.cycles_left;
   assign rsp_if.interval_closed = rsp_ff.interval_closed;
   assign rsp_if.history_value   = rsp_ff.history_value;
   assign rsp_if.next_write_slot = rsp_ff.next_write_slot;

`ifndef ASSERT_OFF
   // Once a request is taken, the block is busy for at least the following cycle.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_if.ready)
      else $error("request accepted back to back");

   // Closing an interval always leaves the running total cleared.
   a_close_clears_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.interval_closed) |-> (rsp_ff.activity_total == '0))
      else $error("closed interval reports a nonzero total");

   // The axis counter never passes the third axis.
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      axis_ff != 2'd3)
      else $error("axis counter out of range");

   // The ring write pointer stays inside the ring.
   a_wslot_range: assert property (@(posedge clock) disable iff (reset)
      9'(wslot_ff) < 9'(HIST_DEPTH))
      else $error("history write pointer out of range");

   // History is written only when a running tick finishes.
   a_ram_write_tick: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (act_ff == ACT_TICK && run_ff && state_ff == ST_DONE))
      else $error("history written outside a running tick");
`endif

endmodule

### rtl/maa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; no package needed.
module maa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/maa_div10.sv
// Shared divide-by-ten unit: signed quotient truncated toward zero, built from
// one constant multiply. Depends on maa_pkg.
module maa_div10 import maa_pkg::*; (
   input  logic signed [ACCEL_W-1:0] dividend,
   output scaled_type                quotient
);

   logic [ACCEL_W-1:0]          mag;
   logic [ACCEL_W+RECIP_W-1:0]  prod;
   logic [SCALED_W-1:0]         quo_mag;

   // The magnitude of the most negative input still fits as an unsigned value.
   assign mag     = dividend[ACCEL_W-1] ? (~dividend + 1'b1) : dividend;
   assign prod    = (ACCEL_W+RECIP_W)'(mag) * (ACCEL_W+RECIP_W)'(RECIP_TEN);
   assign quo_mag = prod[RECIP_SHIFT +: SCALED_W];
   assign quotient = dividend[ACCEL_W-1] ? scaled_type'(~quo_mag + 1'b1)
                                         : scaled_type'(quo_mag);

endmodule

### sim/motion_activity_accumulator_test.sv
// Self-checking testbench of the motion activity accumulator: a directed table, then random
// phases under varied interval settings, checked by a cycle-free predictor or typed responses.
// Depends on maa_pkg, the channel interfaces in maa_if and the motion_activity_accumulator top.
module motion_activity_accumulator_test import maa_pkg::*; ;

   localparam int PERIOD         = 10;
   localparam int RANDOM_ITEMS   = 900;
   localparam int SETTLE_CYCLES  = 16;     // outlasts the longest operation, a running tick
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIVISOR        = 10;     // mg to mg/10, and the change to activity units
   localparam int BREAK_PERCENT  = 26;

   // Action codes the block does not define; they must leave every state alone.
   localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_C = 3'd7;
   // Register index past the last one; a write there is ignored.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = REG_INTERVAL_COUNT + 8'd1;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic signed [ACCEL_W-1:0] accel_x;
      logic signed [ACCEL_W-1:0] accel_y;
      logic signed [ACCEL_W-1:0] accel_z;
      logic [SLOT_W-1:0]         history_slot;
   } request_type;

   typedef enum bit {ROW_REQUEST, ROW_REGISTER} row_kind_type;

   // One line of the directed table: either a request transaction, optionally with its
   // response typed in by hand, or a register write issued once the block is idle.
   typedef struct {
      row_kind_type            kind;
      request_type             req;
      bit                      typed;
      rsp_type                 want;
      logic [CSR_IDX_W-1:0]    reg_index;
      logic [CSR_DATA_W-1:0]   reg_data;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   maa_req_if req_if ();
   maa_rsp_if rsp_if ();
   maa_csr_if csr_if ();

   motion_activity_accumulator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always #(PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Activity predictor. It mirrors the architectural state of the block and is advanced
   // once per accepted request transaction and once per accepted register write.
   // ---------------------------------------------------------------------------------------
   logic [TICKS_W-1:0] ticks_per_interval;
   logic [COUNT_W-1:0] intervals_per_run;
   bit                 running_now;
   int                 scaled_prev [3];
   logic [TOTAL_W-1:0] activity_sum;
   logic [TICKS_W-1:0] ticks_to_close;
   logic [COUNT_W-1:0] intervals_left;
   logic [TOTAL_W-1:0] history_copy [HIST_DEPTH];
   int                 slot_to_write;

   rsp_type pending_status [$];   // predicted responses, oldest first
   int      mismatches = 0;
   bit      calm = 1'b0;          // when set, neither side takes a break

   task automatic report(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatches++;
   endtask

   function automatic bit take_break();
      return !calm && ($urandom_range(99) < BREAK_PERCENT);
   endfunction

   task automatic reload_counters();
      ticks_to_close = ticks_per_interval;
      intervals_left = intervals_per_run;
   endtask

   task automatic reset_activity();
      ticks_per_interval = TICKS_RESET;
      intervals_per_run  = COUNT_RESET;
      running_now        = 1'b0;
      activity_sum       = '0;
      slot_to_write      = 0;
      foreach (scaled_prev[k]) scaled_prev[k] = 0;
      foreach (history_copy[k]) history_copy[k] = '0;
      reload_counters();
   endtask

   // A register write only takes effect when the value actually changes.
   task automatic apply_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      if (idx == REG_INTERVAL_TICKS) begin
         if (data[TICKS_W-1:0] != ticks_per_interval) begin
            ticks_per_interval = data[TICKS_W-1:0];
            ticks_to_close     = data[TICKS_W-1:0];
            activity_sum       = '0;
         end
      end else if (idx == REG_INTERVAL_COUNT) begin
         if (data[COUNT_W-1:0] != intervals_per_run) begin
            intervals_per_run = data[COUNT_W-1:0];
            intervals_left    = data[COUNT_W-1:0];
         end
      end
   endtask

   task automatic advance_activity(input request_type r, output rsp_type status);
      int     accel [3];
      int     now;
      int     delta;
      longint sum;
      bit     closed;
      logic [TOTAL_W-1:0] hist;
      accel[0] = int'(r.accel_x);
      accel[1] = int'(r.accel_y);
      accel[2] = int'(r.accel_z);
      closed   = 1'b0;
      hist     = '0;
      case (r.action)
         ACT_TICK: begin
            if (running_now) begin
               // Each axis: scale to mg/10, take the absolute change, add a tenth of it.
               // Integer division truncates toward zero, as the block does.
               for (int k = 0; k < 3; k++) begin
                  now   = accel[k] / DIVISOR;
                  delta = scaled_prev[k] - now;
                  if (delta < 0) delta = -delta;
                  scaled_prev[k] = now;
                  sum = longint'(activity_sum) + longint'(delta / DIVISOR);
                  activity_sum = (sum > 64'hFFFF_FFFF) ? '1 : sum[TOTAL_W-1:0];
               end
               // A countdown of zero behaves like one and closes on this tick.
               if (ticks_to_close > 1) begin
                  ticks_to_close--;
               end else begin
                  if (intervals_left > 1) begin
                     ticks_to_close = ticks_per_interval;
                     intervals_left--;
                  end else begin
                     intervals_left = '0;
                     running_now    = 1'b0;
                  end
                  if (slot_to_write < HIST_DEPTH) history_copy[slot_to_write] = activity_sum;
                  slot_to_write++;
                  if (slot_to_write >= HIST_DEPTH) slot_to_write = 0;
                  activity_sum = '0;
                  closed       = 1'b1;
               end
            end
         end
         ACT_START: begin
            if (intervals_left == 0) reload_counters();
            running_now = 1'b1;
         end
         ACT_STOP: begin
            running_now = 1'b0;
         end
         ACT_CLEAR: begin
            foreach (history_copy[k]) history_copy[k] = '0;
            slot_to_write = 0;
            activity_sum  = '0;
            reload_counters();
         end
         ACT_READ: begin
            if (int'(r.history_slot) < HIST_DEPTH) hist = history_copy[r.history_slot];
         end
         default: ;
      endcase
      status.running         = running_now;
      status.activity_total  = activity_sum;
      status.cycles_left     = intervals_left;
      status.interval_closed = closed;
      status.history_value   = hist;
      status.next_write_slot = slot_to_write[SLOT_W-1:0];
   endtask

   // ---------------------------------------------------------------------------------------
   // Channel drivers. Every input changes only through a nonblocking assignment right after
   // a rising edge; handshakes are sampled right after the edge, where the values seen are
   // still those the edge itself saw.
   // ---------------------------------------------------------------------------------------
   task automatic send_request(input request_type r, input bit typed = 1'b0,
                               input rsp_type want = '0);
      rsp_type predicted;
      while (take_break()) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      // valid is left high after acceptance so that back-to-back transactions never
      // lower and raise it in the same time step.
      req_if.valid        <= 1'b1;
      req_if.action       <= r.action;
      req_if.accel_x      <= r.accel_x;
      req_if.accel_y      <= r.accel_y;
      req_if.accel_z      <= r.accel_z;
      req_if.history_slot <= r.history_slot;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      advance_activity(r, predicted);
      pending_status.push_back(typed ? want : predicted);
   endtask

   // Hold the sender back until every predicted response has been taken, then let the
   // block run out its longest operation before anything is reconfigured.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      apply_register(idx, data);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------------------------
   function automatic table_row_type request_row(input logic [ACTION_W-1:0] act, input int x,
                                                 input int y, input int z, input int slot);
      table_row_type row;
      row.kind      = ROW_REQUEST;
      row.req       = '{act, ACCEL_W'(x), ACCEL_W'(y), ACCEL_W'(z), SLOT_W'(slot)};
      row.typed     = 1'b0;
      row.want      = '0;
      row.reg_index = '0;
      row.reg_data  = '0;
      return row;
   endfunction

   function automatic table_row_type checked_row(input logic [ACTION_W-1:0] act, input int x,
                                                 input int y, input int z, input int slot,
                                                 input rsp_type want);
      table_row_type row;
      row       = request_row(act, x, y, z, slot);
      row.typed = 1'b1;
      row.want  = want;
      return row;
   endfunction

   function automatic table_row_type register_row(input logic [CSR_IDX_W-1:0] idx,
                                                  input logic [CSR_DATA_W-1:0] data);
      table_row_type row;
      row           = request_row(ACT_TICK, 0, 0, 0, 0);
      row.kind      = ROW_REGISTER;
      row.reg_index = idx;
      row.reg_data  = data;
      return row;
   endfunction

   // Mostly full-scale values, some at the rails, some small enough to test truncation.
   function automatic logic signed [ACCEL_W-1:0] pick_accel();
      case ($urandom_range(9))
         0:       return 14'sh1FFF;
         1:       return 14'sh2000;
         2, 3, 4: return ACCEL_W'(int'($urandom_range(40)) - 20);
         default: return ACCEL_W'($urandom);
      endcase
   endfunction

   // Well-formed traffic: a stopped block is mostly started again, a running one mostly
   // sees ticks; the rest is stops, clears, reads, starts, spare codes and ticks while stopped.
   function automatic request_type random_request(input bit run);
      request_type r;
      int          pick;
      pick           = $urandom_range(99);
      r.accel_x      = pick_accel();
      r.accel_y      = pick_accel();
      r.accel_z      = pick_accel();
      r.history_slot = SLOT_W'($urandom);
      if (!run && pick < 65)  r.action = ACT_START;
      else if (pick < 80)     r.action = ACT_TICK;
      else if (pick < 85)     r.action = ACT_STOP;
      else if (pick < 88)     r.action = ACT_CLEAR;
      else if (pick < 96)     r.action = ACT_READ;
      else if (pick < 97)     r.action = ACT_START;
      else                    r.action = ACTION_W'($urandom_range(ACT_SPARE_A, ACT_SPARE_C));
      if (run && r.action == ACT_STOP && $urandom_range(1)) r.action = ACT_TICK;
      return r;
   endfunction

   function automatic logic [TICKS_W-1:0] pick_ticks();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10)      return '0;
      else if (pick < 70) return TICKS_W'($urandom_range(1, 6));
      else if (pick < 82) return TICKS_W'($urandom_range(7, 40));
      else if (pick < 87) return TICKS_W'(86400);
      else if (pick < 92) return '1;
      else                return TICKS_W'($urandom_range(1, 131071));
   endfunction

   function automatic logic [COUNT_W-1:0] pick_count();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10)      return '0;
      else if (pick < 60) return COUNT_W'($urandom_range(1, 4));
      else if (pick < 75) return COUNT_W'(16);
      else if (pick < 85) return '1;
      else                return COUNT_W'($urandom_range(5, 15));
   endfunction

   // ---------------------------------------------------------------------------------------
   // Response side: random back-pressure, and each response compared field by field with
   // the oldest prediction.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_status.size() == 0) begin
            report("response transaction with no prediction pending");
         end else begin
            want = pending_status.pop_front();
            if (rsp_if.running !== want.running)
               report($sformatf("running: got %0d want %0d", rsp_if.running, want.running));
            if (rsp_if.activity_total !== want.activity_total)
               report($sformatf("activity_total: got %0d want %0d",
                                rsp_if.activity_total, want.activity_total));
            if (rsp_if.cycles_left !== want.cycles_left)
               report($sformatf("cycles_left: got %0d want %0d",
                                rsp_if.cycles_left, want.cycles_left));
            if (rsp_if.interval_closed !== want.interval_closed)
               report($sformatf("interval_closed: got %0d want %0d",
                                rsp_if.interval_closed, want.interval_closed));
            if (rsp_if.history_value !== want.history_value)
               report($sformatf("history_value: got %0d want %0d",
                                rsp_if.history_value, want.history_value));
            if (rsp_if.next_write_slot !== want.next_write_slot)
               report($sformatf("next_write_slot: got %0d want %0d",
                                rsp_if.next_write_slot, want.next_write_slot));
         end
      end
      rsp_if.ready <= !reset && !take_break();
   end

   // The watchdog ends the run if no channel moves a transaction for too long.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------------------------
   table_row_type directed_rows [$];

   initial begin
      table_row_type row;
      request_type   r;
      int            random_sent;
      int            phase;
      int            phase_len;

      req_if.valid        <= 1'b0;
      req_if.action       <= ACT_TICK;
      req_if.accel_x      <= '0;
      req_if.accel_y      <= '0;
      req_if.accel_z      <= '0;
      req_if.history_slot <= '0;
      csr_if.valid        <= 1'b0;
      csr_if.index        <= '0;
      csr_if.data         <= '0;
      reset_activity();

      // Fresh out of reset: stopped, countdown 3600, one interval per run, ring all zero.
      directed_rows.push_back(checked_row(ACT_READ, 0, 0, 0, 3, '{0, 0, 1, 0, 0, 0}));
      // A tick while stopped changes nothing, even at the extremes.
      directed_rows.push_back(checked_row(ACT_TICK, 8191, -8192, 8191, 15,
                                          '{0, 0, 1, 0, 0, 0}));
      // Spare action codes only report status.
      directed_rows.push_back(checked_row(ACT_SPARE_A, -1, -1, -1, 15, '{0, 0, 1, 0, 0, 0}));
      directed_rows.push_back(checked_row(ACT_SPARE_B, 0, 0, 0, 0, '{0, 0, 1, 0, 0, 0}));
      directed_rows.push_back(checked_row(ACT_SPARE_C, 0, 0, 0, 0, '{0, 0, 1, 0, 0, 0}));
      directed_rows.push_back(checked_row(ACT_START, 0, 0, 0, 0, '{1, 0, 1, 0, 0, 0}));
      // Full-scale swings: 819 and 819 scaled units give 81 each.
      directed_rows.push_back(checked_row(ACT_TICK, 8191, -8192, 0, 0,
                                          '{1, 162, 1, 0, 0, 0}));
      directed_rows.push_back(checked_row(ACT_TICK, -8192, 8191, -1, 0,
                                          '{1, 488, 1, 0, 0, 0}));
      // Small values around zero exercise truncation toward zero.
      directed_rows.push_back(request_row(ACT_TICK, 9, -9, 10, 0));
      directed_rows.push_back(request_row(ACT_READ, 0, 0, 0, 0));
      directed_rows.push_back(request_row(ACT_STOP, 0, 0, 0, 0));
      directed_rows.push_back(request_row(ACT_TICK, 4000, 4000, 4000, 0));
      // Zero countdown and zero interval count: one interval closes, then the run ends.
      directed_rows.push_back(register_row(REG_INTERVAL_TICKS, 32'd0));
      directed_rows.push_back(register_row(REG_INTERVAL_COUNT, 32'd0));
      directed_rows.push_back(checked_row(ACT_START, 0, 0, 0, 0, '{1, 0, 0, 0, 0, 0}));
      directed_rows.push_back(request_row(ACT_TICK, 100, 0, 10, 0));
      directed_rows.push_back(request_row(ACT_READ, 0, 0, 0, 0));
      directed_rows.push_back(request_row(ACT_READ, 0, 0, 0, 15));
      // Count above its range is kept as written; one-tick intervals close every tick.
      directed_rows.push_back(register_row(REG_INTERVAL_TICKS, 32'd1));
      directed_rows.push_back(register_row(REG_INTERVAL_COUNT, 32'd31));
      directed_rows.push_back(request_row(ACT_START, 0, 0, 0, 0));
      directed_rows.push_back(request_row(ACT_TICK, -5000, 4000, 123, 0));
      directed_rows.push_back(request_row(ACT_TICK, 0, 0, 0, 0));
      directed_rows.push_back(request_row(ACT_READ, 0, 0, 0, 1));
      directed_rows.push_back(request_row(ACT_CLEAR, 0, 0, 0, 0));
      directed_rows.push_back(request_row(ACT_READ, 0, 0, 0, 1));
      // Largest in-range settings, a write to a missing register, and a rewrite of the
      // same interval length, which must not clear the running total.
      directed_rows.push_back(register_row(REG_INTERVAL_TICKS, 32'd86400));
      directed_rows.push_back(register_row(REG_INTERVAL_COUNT, 32'd16));
      directed_rows.push_back(register_row(REG_UNUSED, 32'hFFFF_FFFF));
      directed_rows.push_back(request_row(ACT_START, 0, 0, 0, 0));
      directed_rows.push_back(request_row(ACT_TICK, 2500, -2500, 7000, 0));
      directed_rows.push_back(register_row(REG_INTERVAL_TICKS, 32'd86400));
      directed_rows.push_back(request_row(ACT_TICK, -2500, 2500, -7000, 0));
      directed_rows.push_back(request_row(ACT_STOP, 0, 0, 0, 0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_REGISTER) begin
            settle();
            write_register(row.reg_index, row.reg_data);
         end else begin
            send_request(row.req, row.typed, row.want);
         end
      end

      // Random phases. Each starts from an idle block with fresh interval settings; the
      // third one runs without any breaks on either side.
      random_sent = 0;
      phase       = 0;
      while (random_sent < RANDOM_ITEMS) begin
         settle();
         calm = (phase == 2);
         write_register(REG_INTERVAL_TICKS,
                        {($urandom_range(3) == 0) ? 15'($urandom) : 15'd0, pick_ticks()});
         write_register(REG_INTERVAL_COUNT,
                        {($urandom_range(3) == 0) ? 27'($urandom) : 27'd0, pick_count()});
         if ($urandom_range(9) == 0) write_register(REG_UNUSED, $urandom);
         phase_len = calm ? 120 : $urandom_range(20, 60);
         repeat (phase_len) begin
            r = random_request(running_now);
            random_sent++;
            send_request(r);
         end
         calm = 1'b0;
         phase++;
      end

      settle();
      if (pending_status.size() != 0) report("predicted responses never arrived");
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
